### design/utf8d_pkg.sv
// shared types, constants and lead byte decoding for the utf-8 stream decoder
package utf8d_pkg;

    localparam int unsigned CP_W = 21;
    localparam int unsigned MAX_RES = 3;
    localparam int unsigned PEND_DEPTH = 3;

    localparam logic [7:0] LEAD1_MASK = 8'h80;
    localparam logic [7:0] LEAD2_MASK = 8'he0;
    localparam logic [7:0] LEAD2_CODE = 8'hc0;
    localparam logic [7:0] LEAD3_MASK = 8'hf0;
    localparam logic [7:0] LEAD3_CODE = 8'he0;
    localparam logic [7:0] LEAD4_MASK = 8'hf8;
    localparam logic [7:0] LEAD4_CODE = 8'hf0;
    localparam logic [7:0] LEAD_BITS = 8'h7f;
    localparam logic [7:0] CONT_BITS = 8'h3f;

    localparam logic STATUS_CHAR = 1'b0;
    localparam logic STATUS_DROP = 1'b1;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_item_t;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            status;
        logic [7:0]      dropped_byte;
        logic            run_end;
    } out_item_t;

    // decoder state carried between items
    typedef struct packed {
        logic [PEND_DEPTH-1:0][7:0] pend;
        logic [1:0]                 cnt;
        logic [2:0]                 len;
        logic [CP_W-1:0]            acc;
    } dec_state_t;

    // results caused by one item
    typedef struct packed {
        out_item_t [MAX_RES-1:0] res;
        logic [1:0]              num;
    } res_set_t;

    // sequence length given by a lead byte, 0 when the byte is no lead
    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] l;
        if ((b & LEAD1_MASK) == 8'h00) l = 3'd1;
        else if ((b & LEAD2_MASK) == LEAD2_CODE) l = 3'd2;
        else if ((b & LEAD3_MASK) == LEAD3_CODE) l = 3'd3;
        else if ((b & LEAD4_MASK) == LEAD4_CODE) l = 3'd4;
        else l = 3'd0;
        return l;
    endfunction

    // payload bits a lead keeps for a sequence of the given length
    function automatic logic [7:0] lead_keep(input logic [7:0] b, input logic [2:0] l);
        logic [7:0] v;
        if (l == 3'd1) v = b;
        else v = b & (LEAD_BITS >> l);
        return v;
    endfunction

endpackage

### design/utf8d_decode.sv
// next state and result set for one accepted byte
module utf8d_decode
    import utf8d_pkg::*;
(
    input  dec_state_t st,
    input  in_item_t   item,
    output dec_state_t st_next,
    output res_set_t   rs
);

    always_comb
    begin
        logic [3:0][7:0]  buf_b;
        logic [2:0]       n;
        logic [2:0]       i;
        logic [2:0]       l;
        logic [2:0]       avail;
        logic [CP_W-1:0]  cp;
        logic [1:0]       pos;
        logic [1:0]       k;
        logic [2:0]       ln;
        logic [CP_W-1:0]  acc_n;

        st_next = st;
        rs = '0;
        buf_b = '0;
        n = 3'd0;
        i = 3'd0;
        l = 3'd0;
        avail = 3'd0;
        cp = '0;
        pos = 2'd0;
        k = 2'd0;
        ln = lead_len(item.in_byte);
        acc_n = {st.acc[CP_W-7:0], item.in_byte[5:0] & CONT_BITS[5:0]};

        if (item.in_last)
        begin
            // end of string: decode buffered bytes plus this one as fresh leads
            for (int p = 0; p < PEND_DEPTH; p++)
            begin
                if (2'(p) < st.cnt)
                    buf_b[p] = st.pend[p];
            end
            buf_b[st.cnt] = item.in_byte;
            n = {1'b0, st.cnt} + 3'd1;
            for (int r = 0; r < MAX_RES; r++)
            begin
                if (i < n)
                begin
                    l = lead_len(buf_b[i[1:0]]);
                    avail = n - i;
                    if (l == 3'd0 || l > avail)
                    begin
                        rs.res[k].status = STATUS_DROP;
                        rs.res[k].dropped_byte = buf_b[i[1:0]];
                        i = i + 3'd1;
                    end
                    else
                    begin
                        cp = CP_W'(lead_keep(buf_b[i[1:0]], l));
                        for (int j = 1; j < 4; j++)
                        begin
                            if (3'(j) < l)
                            begin
                                pos = i[1:0] + 2'(j);
                                cp = {cp[CP_W-7:0], buf_b[pos][5:0]};
                            end
                        end
                        rs.res[k].code_point = cp;
                        rs.res[k].status = STATUS_CHAR;
                        i = i + l;
                    end
                    k = k + 2'd1;
                end
            end
            rs.num = k;
            st_next.cnt = 2'd0;
            st_next.len = 3'd0;
            st_next.acc = '0;
        end
        else if (st.cnt == 2'd0)
        begin
            if (ln == 3'd0)
            begin
                rs.res[0].status = STATUS_DROP;
                rs.res[0].dropped_byte = item.in_byte;
                rs.num = 2'd1;
            end
            else if (ln == 3'd1)
            begin
                rs.res[0].code_point = CP_W'(item.in_byte);
                rs.num = 2'd1;
            end
            else
            begin
                st_next.pend[0] = item.in_byte;
                st_next.cnt = 2'd1;
                st_next.len = ln;
                st_next.acc = CP_W'(lead_keep(item.in_byte, ln));
            end
        end
        else
        begin
            if (({1'b0, st.cnt} + 3'd1) >= st.len)
            begin
                rs.res[0].code_point = acc_n;
                rs.num = 2'd1;
                st_next.cnt = 2'd0;
                st_next.len = 3'd0;
                st_next.acc = '0;
            end
            else
            begin
                st_next.pend[st.cnt] = item.in_byte;
                st_next.cnt = st.cnt + 2'd1;
                st_next.acc = acc_n;
            end
        end

        // flag the final result of this byte
        if (rs.num != 2'd0)
            rs.res[rs.num - 2'd1].run_end = 1'b1;
    end

endmodule

### design/utf8_stream_decoder_top.sv
// top level of the lenient utf-8 stream decoder
//
//  channel | signals                          | moves
//  --------+----------------------------------+---------------------------------
//  byte    | byte_valid, byte_stall, byte_item | one raw byte and end-of-string flag
//  char    | char_valid, char_stall, char_item | one code point or dropped byte
//
// one byte is taken per clock when not back-pressured; a byte causes zero or
// one result, except the final byte of a string, which may cause up to three
// the three-entry result buffer sets the rate: a new byte enters while the
// last buffered result leaves, so extra results of a flush hold off the byte side
// reset clears decoder state and result count, not stored results or pending bytes
// a stall on the char side holds the buffer and back-pressures the byte side
module utf8_stream_decoder_top
    import utf8d_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      byte_valid,
    output logic      byte_stall,
    input  in_item_t  byte_item,
    output logic      char_valid,
    input  logic      char_stall,
    output out_item_t char_item
);

    // decoder state
    logic [PEND_DEPTH-1:0][7:0] pend_reg;
    logic [1:0]                 cnt_reg;
    logic [2:0]                 len_reg;
    logic [CP_W-1:0]            acc_reg;

    // result buffer: entries, how many remain, which one is shown
    out_item_t [MAX_RES-1:0] res_reg;
    logic [1:0]              rem_reg;
    logic [1:0]              idx_reg;

    dec_state_t st;
    dec_state_t st_next;
    res_set_t   rs;
    logic       accept;
    logic       pop;

    assign st.pend = pend_reg;
    assign st.cnt  = cnt_reg;
    assign st.len  = len_reg;
    assign st.acc  = acc_reg;

    utf8d_decode u_dec (
        .st      (st),
        .item    (byte_item),
        .st_next (st_next),
        .rs      (rs)
    );

    assign char_valid = (rem_reg != 2'd0);
    assign char_item  = res_reg[idx_reg];
    assign pop        = char_valid && !char_stall;

    // take a byte when the buffer is empty or its last entry leaves now
    assign byte_stall = !((rem_reg == 2'd0) || (rem_reg == 2'd1 && !char_stall));
    assign accept     = byte_valid && !byte_stall;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            len_reg <= 3'd0;
            acc_reg <= '0;
            rem_reg <= 2'd0;
            idx_reg <= 2'd0;
        end
        else if (accept)
        begin
            cnt_reg <= st_next.cnt;
            len_reg <= st_next.len;
            acc_reg <= st_next.acc;
            rem_reg <= rs.num;
            idx_reg <= 2'd0;
        end
        else if (pop)
        begin
            rem_reg <= rem_reg - 2'd1;
            idx_reg <= idx_reg + 2'd1;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_reg <= st_next.pend;
            res_reg  <= rs.res;
        end
    end

endmodule

### test/tb_top.sv
// self-checking testbench for the lenient utf-8 stream decoder
module tb_top;
    import utf8d_pkg::*;

    localparam int ITEMS_TOTAL = 330;
    localparam int HOLD_CYCLES = 60;
    localparam int DRAIN_CYCLES = 8;
    localparam int REPORT_LIMIT = 50;

    // directed bytes as {last flag, byte}: plain ascii, stray and invalid leads,
    // every sequence length, the largest code point, an overlong form, a
    // non-continuation follower, strings ending inside a sequence and on a lead
    localparam logic [8:0] DIRECTED [25] = '{
        9'h000, 9'h07f, 9'h080, 9'h0ff, 9'h0f8,
        9'h0c3, 9'h0a9,
        9'h0e2, 9'h082, 9'h0ac,
        9'h0f7, 9'h0bf, 9'h0bf, 9'h0bf,
        9'h0c0, 9'h080,
        9'h0c3, 9'h041,
        9'h0e2, 9'h141,
        9'h0f0, 9'h09f, 9'h198,
        9'h1c3,
        9'h1ff
    };

    logic      clk;
    logic      rst_n = 1'b0;
    logic      byte_valid = 1'b0;
    logic      byte_stall;
    in_item_t  byte_item = '0;
    logic      char_valid;
    logic      char_stall = 1'b0;
    out_item_t char_item;

    // bytes still to be offered and results still owed by the block
    in_item_t  bytes_to_send [$];
    out_item_t expected_chars [$];

    // predictor copy of the decoder state
    logic [7:0]      seq_buf [3];
    int              seq_cnt = 0;
    int              seq_len = 0;
    logic [CP_W-1:0] seq_acc = '0;

    int  total_bytes = 0;
    int  strings_sent = 0;
    int  bytes_taken = 0;
    int  codes_seen = 0;
    int  drops_seen = 0;
    int  mismatches = 0;
    logic rx_hold = 1'b0;

    utf8_stream_decoder_top DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_item  (char_item)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    // sequence length announced by a lead byte, zero for a non-lead
    function automatic int lead_width(input logic [7:0] b);
        casez (b)
            8'b0???????: return 1;
            8'b110?????: return 2;
            8'b1110????: return 3;
            8'b11110???: return 4;
            default:     return 0;
        endcase
    endfunction

    // value bits that a lead contributes
    function automatic logic [CP_W-1:0] lead_payload(input logic [7:0] b, input int w);
        if (w == 1)
            return CP_W'(b);
        return CP_W'(b & (LEAD_BITS >> w));
    endfunction

    function automatic logic [CP_W-1:0] add_follower(input logic [CP_W-1:0] v,
                                                     input logic [7:0] b);
        return {v[CP_W-7:0], 6'(b & CONT_BITS)};
    endfunction

    function automatic out_item_t char_result(input logic [CP_W-1:0] v);
        out_item_t o;
        o.code_point = v;
        o.status = STATUS_CHAR;
        o.dropped_byte = 8'h00;
        o.run_end = 1'b0;
        return o;
    endfunction

    function automatic out_item_t drop_result(input logic [7:0] b);
        out_item_t o;
        o.code_point = '0;
        o.status = STATUS_DROP;
        o.dropped_byte = b;
        o.run_end = 1'b0;
        return o;
    endfunction

    // work out the code points and drops that one accepted byte causes
    function automatic void decode_byte(input in_item_t it);
        out_item_t       found [$];
        out_item_t       one;
        logic [7:0]      tail [$];
        logic [CP_W-1:0] v;
        int              w;
        int              i;
        int              j;

        if (it.in_last)
        begin
            // end of string: re-decode whatever is buffered plus this byte
            for (i = 0; i < seq_cnt; i++)
                tail.push_back(seq_buf[i]);
            tail.push_back(it.in_byte);
            i = 0;
            while (i < tail.size() && found.size() < MAX_RES)
            begin
                w = lead_width(tail[i]);
                if (w == 0 || w > tail.size() - i)
                begin
                    found.push_back(drop_result(tail[i]));
                    i++;
                end
                else
                begin
                    v = lead_payload(tail[i], w);
                    for (j = 1; j < w; j++)
                        v = add_follower(v, tail[i + j]);
                    found.push_back(char_result(v));
                    i += w;
                end
            end
            seq_cnt = 0;
            seq_len = 0;
            seq_acc = '0;
        end
        else if (seq_cnt == 0)
        begin
            w = lead_width(it.in_byte);
            if (w == 0)
                found.push_back(drop_result(it.in_byte));
            else if (w == 1)
                found.push_back(char_result(CP_W'(it.in_byte)));
            else
            begin
                seq_buf[0] = it.in_byte;
                seq_cnt = 1;
                seq_len = w;
                seq_acc = lead_payload(it.in_byte, w);
            end
        end
        else
        begin
            // followers are taken as they come, continuation or not
            seq_acc = add_follower(seq_acc, it.in_byte);
            if (seq_cnt + 1 >= seq_len)
            begin
                found.push_back(char_result(seq_acc));
                seq_cnt = 0;
                seq_len = 0;
                seq_acc = '0;
            end
            else
            begin
                seq_buf[seq_cnt] = it.in_byte;
                seq_cnt++;
            end
        end

        for (i = 0; i < found.size(); i++)
        begin
            one = found[i];
            one.run_end = (i == found.size() - 1);
            expected_chars.push_back(one);
        end
    endfunction

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------

    task automatic push_byte(input logic [7:0] b, input logic last);
        in_item_t it;
        it.in_byte = b;
        it.in_last = last;
        bytes_to_send.push_back(it);
        if (last)
            strings_sent++;
    endtask

    // a string of well-formed characters with random content, now and then a
    // stray byte, and sometimes cut short by one or two bytes at its end
    task automatic add_random_string();
        logic [7:0]  s [$];
        logic [31:0] r;
        int          nch;
        int          k;
        int          cut;

        nch = $urandom_range(1, 6);
        for (k = 0; k < nch; k++)
        begin
            r = $urandom;
            case ($urandom_range(0, 9))
                0:
                begin
                    s.push_back(r[7:0]);
                end
                1, 2, 3:
                begin
                    s.push_back({1'b0, r[6:0]});
                end
                4, 5:
                begin
                    s.push_back({3'b110, r[4:0]});
                    s.push_back({2'b10, r[10:5]});
                end
                6, 7:
                begin
                    s.push_back({4'b1110, r[3:0]});
                    s.push_back({2'b10, r[9:4]});
                    s.push_back({2'b10, r[15:10]});
                end
                default:
                begin
                    s.push_back({5'b11110, r[2:0]});
                    s.push_back({2'b10, r[8:3]});
                    s.push_back({2'b10, r[14:9]});
                    s.push_back({2'b10, r[20:15]});
                end
            endcase
        end
        if ($urandom_range(0, 3) == 0 && s.size() > 1)
        begin
            cut = $urandom_range(1, (s.size() > 2) ? 2 : 1);
            repeat (cut)
                void'(s.pop_back());
        end
        for (k = 0; k < s.size(); k++)
            push_byte(s[k], k == s.size() - 1);
    endtask

    // ---------------------------------------------------------------
    // idling: thirds of the run with sender light / receiver heavy,
    // then the reverse, then no idling at all
    // ---------------------------------------------------------------

    function automatic int run_phase();
        return (bytes_taken * 3) / ((total_bytes > 0) ? total_bytes : 1);
    endfunction

    function automatic logic sender_idles();
        int p;
        p = run_phase();
        if (p == 0)
            return $urandom_range(0, 99) < 20;
        if (p == 1)
            return $urandom_range(0, 99) < 84;
        return 1'b0;
    endfunction

    function automatic logic receiver_idles();
        int p;
        p = run_phase();
        if (p == 0)
            return $urandom_range(0, 99) < 84;
        if (p == 1)
            return $urandom_range(0, 99) < 20;
        return 1'b0;
    endfunction

    // ---------------------------------------------------------------
    // driver: an accepted item is predicted at once, a held item stays put
    // ---------------------------------------------------------------

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (byte_valid && !byte_stall)
            begin
                decode_byte(byte_item);
                bytes_taken++;
            end
            if (!byte_valid || !byte_stall)
            begin
                if (bytes_to_send.size() > 0 && !sender_idles())
                begin
                    byte_item <= bytes_to_send.pop_front();
                    byte_valid <= 1'b1;
                end
                else
                begin
                    byte_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // monitor and receiver stall
    // ---------------------------------------------------------------

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("mismatch at %0t: %s", $time, what);
    endtask

    always @(posedge clk)
    begin
        out_item_t want;
        if (char_valid && !char_stall)
        begin
            if (char_item.status == STATUS_DROP)
                drops_seen++;
            else
                codes_seen++;
            if (expected_chars.size() == 0)
            begin
                report_mismatch($sformatf("item with nothing expected: %h", char_item));
            end
            else
            begin
                want = expected_chars.pop_front();
                if (char_item.code_point !== want.code_point)
                    report_mismatch($sformatf("code_point %h, expected %h",
                                              char_item.code_point, want.code_point));
                if (char_item.status !== want.status)
                    report_mismatch($sformatf("status %b, expected %b",
                                              char_item.status, want.status));
                if (char_item.dropped_byte !== want.dropped_byte)
                    report_mismatch($sformatf("dropped_byte %h, expected %h",
                                              char_item.dropped_byte, want.dropped_byte));
                if (char_item.run_end !== want.run_end)
                    report_mismatch($sformatf("run_end %b, expected %b",
                                              char_item.run_end, want.run_end));
            end
        end
        char_stall <= rx_hold || receiver_idles();
    end

    // long receiver hold-offs while the sender keeps offering, so the result
    // buffer fills and the block has to stall its byte side
    initial
    begin
        wait (bytes_taken >= 40);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
        wait (bytes_taken >= (total_bytes * 3) / 4);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------

    initial
    begin
        int k;
        for (k = 0; k < 25; k++)
            push_byte(DIRECTED[k][7:0], DIRECTED[k][8]);
        while (bytes_to_send.size() < ITEMS_TOTAL)
            add_random_string();
        total_bytes = bytes_to_send.size();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // every byte taken and every owed result seen, then a short drain
        while (bytes_taken != total_bytes || expected_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d bytes in %0d strings under three idling mixes",
                 total_bytes, strings_sent);
        $display("checked %0d code points and %0d dropped bytes, %0d mismatches",
                 codes_seen, drops_seen, mismatches);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // safety net far beyond the slowest correct run
    initial
    begin
        #2000000;
        $display("timeout with %0d of %0d bytes taken, %0d results owed",
                 bytes_taken, total_bytes, expected_chars.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
